/* design/aid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_pkg
// Shared types and constants for the ARM-state instruction decoder.
// ----------------------------------------------------------------------------
package aid_pkg;

	typedef enum logic [4:0] {
		CL_UNDEF  = 5'd0,
		CL_DP     = 5'd1,
		CL_MUL    = 5'd2,
		CL_MULL   = 5'd3,
		CL_SWAP   = 5'd4,
		CL_BX     = 5'd5,
		CL_HWREG  = 5'd6,
		CL_HWIMM  = 5'd7,
		CL_SIGNED = 5'd8,
		CL_LDST   = 5'd9,
		CL_BLOCK  = 5'd10,
		CL_BRANCH = 5'd11,
		CL_SWI    = 5'd12,
		CL_PSR    = 5'd13,
		CL_CPDT   = 5'd14,
		CL_CPDO   = 5'd15,
		CL_CPRT   = 5'd16
	} insn_class_t;

	// bits 27-20 of BX Rm
	localparam logic [7:0] BX_OPCODE   = 8'b0001_0010;
	// bits 7-4 patterns
	localparam logic [3:0] NIB_MUL     = 4'b1001;
	localparam logic [3:0] NIB_HW      = 4'b1011;
	localparam logic [3:0] NIB_BX      = 4'b0001;
	localparam logic [3:0] NIB_SGN_MSK = 4'b1101;

	typedef struct packed {
		logic [4:0]  insn_class;
		logic [6:0]  flag_bits;
		logic [3:0]  reg_n;
		logic [3:0]  reg_d;
		logic [3:0]  reg_s;
		logic [3:0]  reg_m;
		logic [3:0]  op_field;
		logic [2:0]  cp_info;
		logic [23:0] payload;
	} decode_t;

endpackage

/* design/aid_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_classify
// Picks one of the 17 instruction classes from bits 27-20 and 7-4.
// ----------------------------------------------------------------------------
module aid_classify (
	input  logic [31:0]         instruction,
	output aid_pkg::insn_class_t insn_class
);

	logic [1:0] top;
	logic       i25;
	logic [3:0] b74;
	logic [3:0] opc;
	logic       cmp_no_s;
	logic       dp_or_psr_psr;

	assign top      = instruction[27:26];
	assign i25      = instruction[25];
	assign b74      = instruction[7:4];
	assign opc      = instruction[24:21];
	// TST/TEQ/CMP/CMN without S are MRS/MSR
	assign cmp_no_s = (opc[3:2] == 2'b10) && !instruction[20];
	assign dp_or_psr_psr = cmp_no_s;

	always_comb begin
		insn_class = aid_pkg::CL_UNDEF;
		unique case (top)
			2'd0: begin
				priority if (i25) begin
					insn_class = dp_or_psr_psr ? aid_pkg::CL_PSR : aid_pkg::CL_DP;
				end else if (b74 == aid_pkg::NIB_MUL) begin
					unique case (instruction[24:23])
						2'd0: insn_class = aid_pkg::CL_MUL;
						2'd1: insn_class = aid_pkg::CL_MULL;
						2'd2: insn_class = aid_pkg::CL_SWAP;
						default: insn_class = aid_pkg::CL_UNDEF;
					endcase
				end else if (b74 == aid_pkg::NIB_HW) begin
					insn_class = instruction[22] ? aid_pkg::CL_HWIMM : aid_pkg::CL_HWREG;
				end else if ((b74 & aid_pkg::NIB_SGN_MSK) == aid_pkg::NIB_SGN_MSK) begin
					insn_class = aid_pkg::CL_SIGNED;
				end else if (b74 == aid_pkg::NIB_BX
						&& instruction[27:20] == aid_pkg::BX_OPCODE) begin
					insn_class = aid_pkg::CL_BX;
				end else begin
					insn_class = dp_or_psr_psr ? aid_pkg::CL_PSR : aid_pkg::CL_DP;
				end
			end
			2'd1: begin
				insn_class = (i25 && instruction[4]) ? aid_pkg::CL_UNDEF : aid_pkg::CL_LDST;
			end
			2'd2: begin
				insn_class = i25 ? aid_pkg::CL_BRANCH : aid_pkg::CL_BLOCK;
			end
			default: begin
				priority if (!i25) begin
					insn_class = aid_pkg::CL_CPDT;
				end else if (instruction[24]) begin
					insn_class = aid_pkg::CL_SWI;
				end else begin
					insn_class = instruction[4] ? aid_pkg::CL_CPRT : aid_pkg::CL_CPDO;
				end
			end
		endcase
	end

endmodule

/* design/aid_fields.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_fields
// Extracts flags, register numbers, opcode and payload for a given class.
// Fields a class does not use are driven to zero.
// ----------------------------------------------------------------------------
module aid_fields (
	input  logic [31:0]          instruction,
	input  aid_pkg::insn_class_t insn_class,
	output aid_pkg::decode_t     dec
);

	logic       f_i, f_p, f_u, f_b, f_w, f_s, f_h;
	logic [3:0] r16, r12, r8, r0;
	logic [7:0] imm8;

	assign f_i  = instruction[25];
	assign f_p  = instruction[24];
	assign f_u  = instruction[23];
	assign f_b  = instruction[22];
	assign f_w  = instruction[21];
	assign f_s  = instruction[20];
	assign f_h  = instruction[5];
	assign r16  = instruction[19:16];
	assign r12  = instruction[15:12];
	assign r8   = instruction[11:8];
	assign r0   = instruction[3:0];
	assign imm8 = {r8, r0};

	always_comb begin
		dec            = '0;
		dec.insn_class = insn_class;
		unique case (insn_class)
			aid_pkg::CL_DP: begin
				dec.flag_bits = {f_i, 4'b0000, f_s, 1'b0};
				dec.op_field  = instruction[24:21];
				dec.reg_n     = r16;
				dec.reg_d     = r12;
				dec.payload   = {12'd0, instruction[11:0]};
			end
			aid_pkg::CL_MUL: begin
				dec.flag_bits = {4'b0000, f_w, f_s, 1'b0};
				dec.reg_d     = r16;
				dec.reg_n     = r12;
				dec.reg_s     = r8;
				dec.reg_m     = r0;
			end
			aid_pkg::CL_MULL: begin
				dec.flag_bits = {3'b000, f_b, f_w, f_s, 1'b0};
				dec.reg_n     = r16;
				dec.reg_d     = r12;
				dec.reg_s     = r8;
				dec.reg_m     = r0;
			end
			aid_pkg::CL_SWAP: begin
				dec.flag_bits = {3'b000, f_b, 3'b000};
				dec.reg_n     = r16;
				dec.reg_d     = r12;
				dec.reg_m     = r0;
			end
			aid_pkg::CL_BX: begin
				// target register shows up in reg_n
				dec.reg_n = r0;
			end
			aid_pkg::CL_HWREG: begin
				dec.flag_bits = {1'b0, f_p, f_u, 1'b0, f_w, f_s, 1'b0};
				dec.reg_n     = r16;
				dec.reg_d     = r12;
				dec.reg_m     = r0;
			end
			aid_pkg::CL_HWIMM: begin
				dec.flag_bits = {1'b0, f_p, f_u, 1'b0, f_w, f_s, 1'b0};
				dec.reg_n     = r16;
				dec.reg_d     = r12;
				dec.payload   = {16'd0, imm8};
			end
			aid_pkg::CL_SIGNED: begin
				dec.flag_bits = {1'b0, f_p, f_u, f_b, f_w, f_s, f_h};
				dec.reg_n     = r16;
				dec.reg_d     = r12;
				if (f_b) begin
					dec.payload = {16'd0, imm8};
				end else begin
					dec.reg_m = r0;
				end
			end
			aid_pkg::CL_LDST: begin
				dec.flag_bits = {f_i, f_p, f_u, f_b, f_w, f_s, 1'b0};
				dec.reg_n     = r16;
				dec.reg_d     = r12;
				dec.payload   = {12'd0, instruction[11:0]};
			end
			aid_pkg::CL_BLOCK: begin
				dec.flag_bits = {1'b0, f_p, f_u, f_b, f_w, f_s, 1'b0};
				dec.reg_n     = r16;
				dec.payload   = {8'd0, instruction[15:0]};
			end
			aid_pkg::CL_BRANCH: begin
				dec.flag_bits = {1'b0, f_p, 5'b00000};
				dec.payload   = instruction[23:0];
			end
			aid_pkg::CL_SWI: begin
				dec.payload = instruction[23:0];
			end
			aid_pkg::CL_PSR: begin
				dec.flag_bits = {f_i, 2'b00, f_b, 3'b000};
				dec.op_field  = instruction[24:21];
				dec.reg_d     = r12;
				dec.payload   = {12'd0, instruction[11:0]};
			end
			aid_pkg::CL_CPDT: begin
				dec.flag_bits = {1'b0, f_p, f_u, f_b, f_w, f_s, 1'b0};
				dec.reg_n     = r16;
				dec.reg_d     = r12;
				dec.reg_s     = r8;
				dec.payload   = {16'd0, instruction[7:0]};
			end
			aid_pkg::CL_CPDO: begin
				dec.op_field = instruction[23:20];
				dec.reg_n    = r16;
				dec.reg_d    = r12;
				dec.reg_s    = r8;
				dec.cp_info  = instruction[7:5];
				dec.reg_m    = r0;
			end
			aid_pkg::CL_CPRT: begin
				dec.flag_bits = {5'b00000, f_s, 1'b0};
				dec.op_field  = {1'b0, instruction[23:21]};
				dec.reg_n     = r16;
				dec.reg_d     = r12;
				dec.reg_s     = r8;
				dec.cp_info   = instruction[7:5];
				dec.reg_m     = r0;
			end
			default: begin
				// undefined: only the class code (zero) goes out
			end
		endcase
	end

endmodule

/* design/arm_instruction_decoder_top.sv */
`timescale 1ns / 1ps
// A taken word goes to the input register, its decode to the result register that drives done.
// Throughput: one word per cycle; busy is never raised, decode is one register-to-register pass.
// Result beats last exactly one cycle and cannot be stalled.
// Reset (arst_n low, asynchronous) clears the valid flags; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
// arm_instruction_decoder_top
// ARM-state instruction decoder: input register, class and field decode,
// result register with a one-cycle done strobe.
// ----------------------------------------------------------------------------
module arm_instruction_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] instruction,
	output logic        done,
	output logic [3:0]  cond_code,
	output logic [4:0]  insn_class,
	output logic [6:0]  flag_bits,
	output logic [3:0]  reg_n,
	output logic [3:0]  reg_d,
	output logic [3:0]  reg_s,
	output logic [3:0]  reg_m,
	output logic [3:0]  op_field,
	output logic [2:0]  cp_info,
	output logic [23:0] payload
);

	logic                 valid_s1;
	logic [31:0]          instruction_s1;
	aid_pkg::insn_class_t class_c;
	aid_pkg::decode_t     dec_c;
	logic                 valid_s2;
	logic [3:0]           cond_s2;
	aid_pkg::decode_t     dec_s2;
	logic                 take;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			instruction_s1 <= instruction;
		end
		if (valid_s1) begin
			cond_s2 <= instruction_s1[31:28];
			dec_s2  <= dec_c;
		end
	end

	aid_classify u_classify (
		.instruction (instruction_s1),
		.insn_class  (class_c)
	);

	aid_fields u_fields (
		.instruction (instruction_s1),
		.insn_class  (class_c),
		.dec         (dec_c)
	);

	assign done       = valid_s2;
	assign cond_code  = cond_s2;
	assign insn_class = dec_s2.insn_class;
	assign flag_bits  = dec_s2.flag_bits;
	assign reg_n      = dec_s2.reg_n;
	assign reg_d      = dec_s2.reg_d;
	assign reg_s      = dec_s2.reg_s;
	assign reg_m      = dec_s2.reg_m;
	assign op_field   = dec_s2.op_field;
	assign cp_info    = dec_s2.cp_info;
	assign payload    = dec_s2.payload;

endmodule

/* design/aid_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_checker
// Port-level checks on the decoder: beat timing and decode invariants.
// ----------------------------------------------------------------------------
module aid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] instruction,
	input logic        done,
	input logic [3:0]  cond_code,
	input logic [4:0]  insn_class,
	input logic [6:0]  flag_bits,
	input logic [3:0]  reg_n,
	input logic [3:0]  reg_d,
	input logic [3:0]  reg_s,
	input logic [3:0]  reg_m,
	input logic [3:0]  op_field,
	input logic [2:0]  cp_info,
	input logic [23:0] payload
);

	// every accepted beat comes out as a done beat
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted word produced no result");

	// no result without an accepted word before it
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted word");

	a_cond_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> cond_code == $past(instruction[31:28], 2))
		else $error("condition field does not match the accepted word");

	a_undef_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && insn_class == aid_pkg::CL_UNDEF |->
			flag_bits == '0 && reg_n == '0 && reg_d == '0 && reg_s == '0
			&& reg_m == '0 && op_field == '0 && cp_info == '0 && payload == '0)
		else $error("undefined class with nonzero fields");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> insn_class <= aid_pkg::CL_CPRT)
		else $error("class code out of range");

endmodule

bind arm_instruction_decoder_top aid_checker u_aid_checker (.*);
